// File: hdl/loc_record_text_to_wire_macros.svh
// assertion macros for the loc record parser
`ifndef LOC_RECORD_TEXT_TO_WIRE_MACROS_SVH
`define LOC_RECORD_TEXT_TO_WIRE_MACROS_SVH
`ifndef SYNTHESIS
`define LRTW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrtw assertion failed");
`define LRTW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrtw assertion failed");
`else
`define LRTW_ASSERT_NOW(lbl, ante, cons)
`define LRTW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hdl/lrtw_pkg.sv
// shared types and constants for the loc record parser
package lrtw_pkg;
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_CHAR = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  localparam logic [4:0] F_LAT_DEG = 5'd0;
  localparam logic [4:0] F_LAT_MIN = 5'd1;
  localparam logic [4:0] F_LAT_SEC = 5'd2;
  localparam logic [4:0] F_LAT_FRAC = 5'd3;
  localparam logic [4:0] F_LON_DEG = 5'd4;
  localparam logic [4:0] F_LON_MIN = 5'd5;
  localparam logic [4:0] F_LON_SEC = 5'd6;
  localparam logic [4:0] F_LON_FRAC = 5'd7;
  localparam logic [4:0] F_ALT = 5'd8;
  localparam logic [4:0] F_ALT_FRAC = 5'd9;
  localparam logic [4:0] F_SIZE = 5'd10;
  localparam logic [4:0] F_SIZE_FRAC = 5'd11;
  localparam logic [4:0] F_HORIZ = 5'd12;
  localparam logic [4:0] F_HORIZ_FRAC = 5'd13;
  localparam logic [4:0] F_VERT = 5'd14;
  localparam logic [4:0] F_VERT_FRAC = 5'd15;

  localparam logic [31:0] ALT_BASE = 32'd10000000;
  localparam logic [31:0] HALF_CIRCLE = 32'h8000_0000;
  localparam logic [31:0] MS_PER_DEG = 32'd3600000;
  localparam logic [31:0] MS_PER_MIN = 32'd60000;
  localparam logic [31:0] MS_PER_SEC = 32'd1000;
  localparam logic [31:0] CM_PER_M = 32'd100;
  localparam logic [31:0] DEF_SIZE = 32'd100;
  localparam logic [31:0] DEF_HORIZ = 32'd1000000;
  localparam logic [31:0] DEF_VERT = 32'd1000;
  localparam logic [31:0] TEN = 32'd10;
  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

  typedef struct packed {
    logic        start;
    logic [31:0] value;
  } cu_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cu_stat_t;
endpackage

// File: hdl/lrtw_in_if.sv
// input channel carrying record text transactions
interface lrtw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] char_code;
  modport source(output valid, output mode, output char_code, input ready);
  modport sink(input valid, input mode, input char_code, output ready);
endinterface

// File: hdl/lrtw_out_if.sv
// output channel carrying encoded loc record transactions
interface lrtw_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  size_code;
  logic [7:0]  horiz_code;
  logic [7:0]  vert_code;
  logic [31:0] latitude_out;
  logic [31:0] longitude_out;
  logic [31:0] altitude_out;
  logic        format_error;
  modport source(output valid, output size_code, output horiz_code, output vert_code,
                 output latitude_out, output longitude_out, output altitude_out,
                 output format_error, input ready);
  modport sink(input valid, input size_code, input horiz_code, input vert_code,
               input latitude_out, input longitude_out, input altitude_out,
               input format_error, output ready);
endinterface

// File: hdl/lrtw_code_unit.sv
// iterative mantissa/exponent encoder for size and precision values
module lrtw_code_unit (
  input  logic               clk,
  input  logic               rst,
  input  lrtw_pkg::cu_ctrl_t ctrl,
  output lrtw_pkg::cu_stat_t stat,
  output logic [7:0]         code
);
  import lrtw_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_FIND = 3'b010,
    C_BASE = 3'b100
  } cstate_t;

  cstate_t     state;
  logic [31:0] x;
  logic [31:0] r;
  logic [3:0]  power;
  logic [3:0]  base;
  logic        done;
  logic [35:0] x10;

  assign x10 = {1'b0, x, 3'b000} + {3'b000, x, 1'b0};
  assign stat.busy = (state != C_IDLE);
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (ctrl.start) begin
            x <= 32'd1;
            r <= ctrl.value;
            power <= 4'd0;
            base <= 4'd0;
            state <= C_FIND;
          end
        end
        C_FIND: begin
          if (x10 <= {4'b0000, r}) begin
            x <= x10[31:0];
            power <= power + 4'd1;
          end else begin
            state <= C_BASE;
          end
        end
        C_BASE: begin
          if (r >= x) begin
            r <= r - x;
            base <= base + 4'd1;
          end else begin
            code <= {base, power};
            done <= 1'b1;
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/loc_record_text_to_wire.sv
// loc record text parser: digits and separator characters are taken in S_IDLE; a number closes via S_MUL and S_APPLY
// closing a fraction scales it on the shared multiplier in S_SCALE, one step per digit to add or drop
// finish runs the encoder three times in S_CODE, then loads the output register in S_OUT
// the output register lets a new transaction enter while the last result waits
// rst is synchronous: clears the sequencer, parse state and output valid
`include "loc_record_text_to_wire_macros.svh"
module loc_record_text_to_wire (
  input logic         clk,
  input logic         rst,
  lrtw_in_if.sink     din,
  lrtw_out_if.source  dout
);
  import lrtw_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_SCALE = 6'b000100,
    S_APPLY = 6'b001000,
    S_CODE  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t      state;
  logic [1:0]  phase;
  logic [4:0]  field;
  logic [31:0] acc;
  logic [3:0]  dcnt;
  logic        neg;
  logic [31:0] lat;
  logic [31:0] lon;
  logic [31:0] alt;
  logic [31:0] size_cm;
  logic [31:0] horiz_cm;
  logic [31:0] vert_cm;
  logic        err;
  logic        dot;
  logic [31:0] term;
  logic [1:0]  idx;
  logic        run;
  logic [7:0]  c_size;
  logic [7:0]  c_horiz;
  logic [7:0]  c_vert;
  logic        out_valid;
  logic [7:0]  o_size;
  logic [7:0]  o_horiz;
  logic [7:0]  o_vert;
  logic [31:0] o_lat;
  logic [31:0] o_lon;
  logic [31:0] o_alt;
  logic        o_err;

  logic [7:0]  c;
  logic [7:0]  u;
  logic        is_dig;
  logic        is_sp;
  logic [31:0] dval;
  logic [31:0] acc_x10;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [3:0]  want;
  logic        is_frac;
  logic        has_frac;
  logic [4:0]  field_next;
  cu_ctrl_t    cu_ctrl;
  cu_stat_t    cu_stat;
  logic [7:0]  cu_code;

  assign c = din.char_code;
  assign u = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
  assign is_dig = (c >= 8'h30 && c <= 8'h39);
  assign is_sp = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  assign dval = {24'd0, c - 8'h30};
  assign acc_x10 = {acc[28:0], 3'b000} + {acc[30:0], 1'b0} + dval;

  always_comb begin
    is_frac = 1'b0;
    has_frac = 1'b0;
    case (field) inside
      F_LAT_FRAC, F_LON_FRAC, F_ALT_FRAC, F_SIZE_FRAC, F_HORIZ_FRAC, F_VERT_FRAC:
        is_frac = 1'b1;
      F_LAT_SEC, F_LON_SEC, F_ALT, F_SIZE, F_HORIZ, F_VERT:
        has_frac = 1'b1;
      default: ;
    endcase
  end

  assign want = (field == F_LAT_FRAC || field == F_LON_FRAC) ? 4'd3 : 4'd2;

  always_comb begin
    if (state == S_SCALE) begin
      mul_b = (dcnt < want) ? TEN : RECIP_TEN;
    end else begin
      case (field)
        F_LAT_DEG, F_LON_DEG: mul_b = MS_PER_DEG;
        F_LAT_MIN, F_LON_MIN: mul_b = MS_PER_MIN;
        F_LAT_SEC, F_LON_SEC: mul_b = MS_PER_SEC;
        default:              mul_b = CM_PER_M;
      endcase
    end
  end

  assign prod = {32'd0, acc} * {32'd0, mul_b};
  assign field_next = field + ((has_frac && !dot) ? 5'd2 : 5'd1);

  always_comb begin
    cu_ctrl.start = (state == S_CODE) && !run;
    case (idx)
      2'd0:    cu_ctrl.value = size_cm;
      2'd1:    cu_ctrl.value = horiz_cm;
      default: cu_ctrl.value = vert_cm;
    endcase
  end

  lrtw_code_unit u_code (
    .clk  (clk),
    .rst  (rst),
    .ctrl (cu_ctrl),
    .stat (cu_stat),
    .code (cu_code)
  );

  assign din.ready = (state == S_IDLE);
  assign dout.valid = out_valid;
  assign dout.size_code = o_size;
  assign dout.horiz_code = o_horiz;
  assign dout.vert_code = o_vert;
  assign dout.latitude_out = o_lat;
  assign dout.longitude_out = o_lon;
  assign dout.altitude_out = o_alt;
  assign dout.format_error = o_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_START;
      field <= F_LAT_DEG;
      acc <= '0;
      dcnt <= '0;
      neg <= 1'b0;
      lat <= '0;
      lon <= '0;
      alt <= '0;
      size_cm <= '0;
      horiz_cm <= '0;
      vert_cm <= '0;
      err <= 1'b0;
      run <= 1'b0;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && dout.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (din.valid) begin
            case (din.mode)
              MODE_START: begin
                phase <= PH_START;
                field <= F_LAT_DEG;
                acc <= '0;
                dcnt <= '0;
                neg <= 1'b0;
                lat <= '0;
                lon <= '0;
                alt <= '0;
                size_cm <= '0;
                horiz_cm <= '0;
                vert_cm <= '0;
                err <= 1'b0;
              end
              MODE_CHAR: begin
                if (!err) begin
                  if (phase == PH_DIGITS) begin
                    if (is_dig) begin
                      acc <= acc_x10;
                      if (dcnt != 4'd15) begin
                        dcnt <= dcnt + 4'd1;
                      end
                    end else begin
                      dot <= (c == 8'h2E);
                      state <= is_frac ? S_SCALE : S_MUL;
                    end
                  end else if (phase == PH_DONE) begin
                    if (!is_sp) begin
                      err <= 1'b1;
                    end
                  end else if (!is_sp) begin
                    if (is_dig) begin
                      acc <= dval;
                      dcnt <= 4'd1;
                      phase <= PH_DIGITS;
                    end else if ((u == 8'h4E || u == 8'h53) && field > F_LAT_DEG
                                 && field <= F_LON_DEG) begin
                      lat <= (u == 8'h4E) ? lat + HALF_CIRCLE : HALF_CIRCLE - lat;
                      field <= F_LON_DEG;
                    end else if ((u == 8'h45 || u == 8'h57) && field > F_LON_DEG
                                 && field <= F_ALT) begin
                      lon <= (u == 8'h45) ? lon + HALF_CIRCLE : HALF_CIRCLE - lon;
                      field <= F_ALT;
                    end else if (c == 8'h2D && field == F_ALT) begin
                      neg <= 1'b1;
                    end else begin
                      err <= 1'b1;
                    end
                  end
                end
              end
              MODE_FINISH: begin
                if (field <= F_SIZE) size_cm <= DEF_SIZE;
                if (field <= F_HORIZ) horiz_cm <= DEF_HORIZ;
                if (field <= F_VERT) vert_cm <= DEF_VERT;
                idx <= 2'd0;
                run <= 1'b0;
                state <= S_CODE;
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          term <= prod[31:0];
          state <= S_APPLY;
        end
        S_SCALE: begin
          if (dcnt < want) begin
            acc <= prod[31:0];
            dcnt <= dcnt + 4'd1;
          end else if (dcnt > want) begin
            acc <= {3'b000, prod[63:35]};
            dcnt <= dcnt - 4'd1;
          end else begin
            term <= acc;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          case (field)
            F_LAT_DEG:                        lat <= term;
            F_LAT_MIN, F_LAT_SEC, F_LAT_FRAC: lat <= lat + term;
            F_LON_DEG:                        lon <= term;
            F_LON_MIN, F_LON_SEC, F_LON_FRAC: lon <= lon + term;
            F_ALT:        alt <= neg ? ALT_BASE - term : ALT_BASE + term;
            F_ALT_FRAC:   alt <= neg ? alt - term : alt + term;
            F_SIZE:       size_cm <= term;
            F_SIZE_FRAC:  size_cm <= size_cm + term;
            F_HORIZ:      horiz_cm <= term;
            F_HORIZ_FRAC: horiz_cm <= horiz_cm + term;
            F_VERT:       vert_cm <= term;
            F_VERT_FRAC:  vert_cm <= vert_cm + term;
            default: ;
          endcase
          field <= field_next;
          phase <= (field_next <= F_VERT_FRAC) ? PH_START : PH_DONE;
          state <= S_IDLE;
        end
        S_CODE: begin
          if (!run) begin
            run <= 1'b1;
          end else if (cu_stat.done) begin
            run <= 1'b0;
            case (idx)
              2'd0:    c_size <= cu_code;
              2'd1:    c_horiz <= cu_code;
              default: c_vert <= cu_code;
            endcase
            if (idx == 2'd2) begin
              state <= S_OUT;
            end else begin
              idx <= idx + 2'd1;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || dout.ready) begin
            o_size <= c_size;
            o_horiz <= c_horiz;
            o_vert <= c_vert;
            o_lat <= lat;
            o_lon <= lon;
            o_alt <= alt;
            o_err <= err;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LRTW_ASSERT_NOW(a_done_in_code, cu_stat.done, state == S_CODE)
  `LRTW_ASSERT_NOW(a_scale_on_frac, state == S_SCALE, is_frac)
  `LRTW_ASSERT_NOW(a_done_phase_field, phase == PH_DONE, field > F_VERT_FRAC)
  `LRTW_ASSERT_NOW(a_unit_idle, state == S_IDLE, !cu_stat.busy)
  `LRTW_ASSERT_NEXT(a_out_loads, state == S_OUT && (!out_valid || dout.ready), out_valid)
endmodule
